[design/ps2kbs_pkg.sv]
package ps2kbs_pkg;

	// Input item kinds carried on s_tuser.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_PUSH = 1'b1;

	// Configuration register word index (paddr[2]).
	localparam logic REG_HALF_PERIOD = 1'b0;

	// Reset and frame constants.
	localparam logic [15:0] HALF_PERIOD_RESET = 16'd2000;
	localparam logic [4:0]  FINAL_PHASE       = 5'd26;
	localparam int          QUEUE_DEPTH_DEFAULT = 256;

	// Field widths.
	localparam int BYTE_W    = 8;
	localparam int TICK_W    = 16;
	localparam int PHASE_W   = 5;
	localparam int QCOUNT_W  = 9;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;

	// Bit positions inside the result tdata.
	localparam int OUT_CLOCK_BIT   = 0;
	localparam int OUT_DATA_BIT    = 1;
	localparam int OUT_COUNT_LSB   = 2;
	localparam int OUT_COUNT_MSB   = 10;
	localparam int OUT_DROPPED_BIT = 11;
	localparam int OUT_SENT_BIT    = 12;

endpackage

[design/ps2_keyboard_byte_sender_core.sv]
// PS/2 device-side byte sender. Each input item is either a time tick (s_tuser = 0) or a
// scan-code push (s_tuser = 1, byte on s_tdata); every accepted item yields exactly one
// result item carrying the clock and data line levels, the queue fill, and the dropped and
// sent flags. The block takes one item per clock cycle and shows its result in the cycle after
// acceptance. A single result register sits on the output: a new item enters when that
// register is empty or its result leaves in the same cycle, so a stalled result stalls the
// input. Bytes wait in a QUEUE_DEPTH-entry RAM with a registered read port that presents
// the head entry; a push into a full queue is discarded and flagged. half_period (APB
// offset 0, reset 2000) sets the ticks per half-bit phase.
module ps2_keyboard_byte_sender_core
	import ps2kbs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input items.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] push_byte
	input  logic                   s_tuser,   // [0] cmd
	// Result items.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] line_clock, [1] line_data, [10:2] queue_count, [11] push_dropped,
	// [12] byte_sent, [15:13] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// Configuration port.
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	// Architectural state.
	logic [TICK_W-1:0]  half_period_q;
	logic [PTR_W-1:0]   head_q, head_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [TICK_W-1:0]  tick_q, tick_d;
	logic               clock_q, clock_d;
	logic               data_q, data_d;

	// Result register.
	logic               out_valid_q;
	logic               out_clock_q, out_data_q, out_dropped_q, out_sent_q;
	logic [QCOUNT_W-1:0] out_count_q;

	logic               accept;
	logic               dropped, sent;
	logic               wr_en;
	logic [PTR_W-1:0]   tail;
	logic [SUM_W-1:0]   tail_sum;
	logic [PTR_W-1:0]   head_inc;
	logic [TICK_W:0]    tick_next;
	logic [BYTE_W-1:0]  head_byte;
	logic [3:0]         bit_pos;
	logic               cfg_wr;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_HALF_PERIOD) ? {16'd0, half_period_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_wr && paddr[2] == REG_HALF_PERIOD) begin
			half_period_q <= pwdata[TICK_W-1:0];
		end
	end

	// Queue slot arithmetic, modulo the queue depth.
	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH))
		? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
	assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	// The RAM always reads the slot that will be the head after this edge.
	ps2kbs_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(tail),
		.wr_data(s_tdata[BYTE_W-1:0]),
		.rd_addr(head_d),
		.rd_data(head_byte)
	);

	// Data bit index is half the phase, minus one for the start bit.
	assign tick_next = {1'b0, tick_q} + 1'b1;
	assign bit_pos   = phase_q[4:1] - 4'd1;

	// Next state for one item: push, or tick through the prescaler and frame phases.
	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		phase_d = phase_q;
		tick_d  = tick_q;
		clock_d = clock_q;
		data_d  = data_q;
		dropped = 1'b0;
		sent    = 1'b0;
		wr_en   = 1'b0;
		if (accept) begin
			if (s_tuser == CMD_PUSH) begin
				if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
					dropped = 1'b1;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
				end
			end else if (count_q != '0) begin
				if (tick_next >= {1'b0, half_period_q}) begin
					tick_d = '0;
					if (phase_q >= FINAL_PHASE) begin
						head_d  = head_inc;
						count_d = count_q - 1'b1;
						phase_d = '0;
						clock_d = 1'b1;
						sent    = 1'b1;
					end else begin
						clock_d = phase_q[0];
						phase_d = phase_q + 1'b1;
						case (phase_q) inside
							[5'd0:5'd1]:   data_d = 1'b0;
							[5'd2:5'd17]:  data_d = head_byte[bit_pos[2:0]];
							[5'd18:5'd19]: data_d = ~^head_byte;
							[5'd20:5'd21]: data_d = 1'b1;
							default: begin
								clock_d = 1'b1;
								data_d  = 1'b1;
							end
						endcase
					end
				end else begin
					tick_d = tick_next[TICK_W-1:0];
				end
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			phase_q <= '0;
			tick_q  <= '0;
			clock_q <= 1'b1;
			data_q  <= 1'b1;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			phase_q <= phase_d;
			tick_q  <= tick_d;
			clock_q <= clock_d;
			data_q  <= data_d;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= accept;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_clock_q   <= clock_d;
			out_data_q    <= data_d;
			out_count_q   <= QCOUNT_W'(count_d);
			out_dropped_q <= dropped;
			out_sent_q    <= sent;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_sent_q, out_dropped_q, out_count_q, out_data_q, out_clock_q};

endmodule

[design/ps2kbs_ram.sv]
module ps2kbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[design/ps2kbs_checker.sv]
module ps2kbs_checker
	import ps2kbs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam logic [QCOUNT_W-1:0] FULL_COUNT = QCOUNT_W'(QUEUE_DEPTH);

	// A stalled result item holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result item changed while stalled");

	// A tick never drops and a push never finishes a byte.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[OUT_DROPPED_BIT] && m_tdata[OUT_SENT_BIT]))
		else $error("dropped and sent flags both set");

	// A dropped push means the queue is full.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_DROPPED_BIT]
		|-> m_tdata[OUT_COUNT_MSB:OUT_COUNT_LSB] == FULL_COUNT)
		else $error("push dropped while queue not full");

	// A finished byte releases the clock line.
	a_sent_clock: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_SENT_BIT] |-> m_tdata[OUT_CLOCK_BIT])
		else $error("clock line low after a byte was sent");

	// With nothing queued both lines idle high.
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_COUNT_MSB:OUT_COUNT_LSB] == '0
		|-> m_tdata[OUT_CLOCK_BIT] && m_tdata[OUT_DATA_BIT])
		else $error("lines not idle with an empty queue");

endmodule

bind ps2_keyboard_byte_sender_core ps2kbs_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_ps2kbs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench
	import ps2kbs_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_AT_RESULT = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;
	localparam int TICKS_PER_BYTE = 27;
	localparam int DRAIN_BYTES = 6;

	// Register byte addresses: one real register and one unused slot.
	localparam logic [2:0] HALF_PERIOD_ADDR = {REG_HALF_PERIOD, 2'b00};
	localparam logic [2:0] UNUSED_ADDR = {~REG_HALF_PERIOD, 2'b00};

	// Last phase of each part of the frame.
	localparam logic [PHASE_W-1:0] PH_START_END = 5'd1;
	localparam logic [PHASE_W-1:0] PH_DATA_END = 5'd17;
	localparam logic [PHASE_W-1:0] PH_PARITY_END = 5'd19;
	localparam logic [PHASE_W-1:0] PH_STOP_END = 5'd21;

	typedef struct {
		logic cmd;
		logic [BYTE_W-1:0] data;
	} key_item_t;

	typedef struct packed {
		logic sent;
		logic dropped;
		logic [QCOUNT_W-1:0] count;
		logic data;
		logic clock;
	} line_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;   // [7:0] push_byte
	logic s_tuser = CMD_TICK;              // [0] cmd
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [0] line_clock, [1] line_data, [10:2] queue_count, [11] push_dropped,
	// [12] byte_sent, [15:13] zero
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Shadow copy of the sender's state.
	logic [BYTE_W-1:0] kb_queue [QUEUE_DEPTH_DEFAULT];
	logic [BYTE_W-1:0] kb_head;
	logic [QCOUNT_W-1:0] kb_count;
	logic [PHASE_W-1:0] kb_phase;
	logic [TICK_W-1:0] kb_ticks;
	logic kb_clk_lvl;
	logic kb_dat_lvl;
	logic [TICK_W-1:0] kb_half_period;

	key_item_t pending_items[$];
	key_item_t next_item;
	line_result_t line_expect_q[$];
	int items_queued = 0;
	int results_seen = 0;
	int fail_count = 0;
	int send_gap;
	bit send_burst;
	int recv_left;
	bit recv_burst;
	int quiet_cycles = 0;

	ps2_keyboard_byte_sender_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, 7);
	endfunction

	// Advances the shadow state by one item and returns the line levels after it.
	task automatic predict_line_levels(input logic cmd, input logic [BYTE_W-1:0] pbyte,
			output line_result_t r);
		logic [TICK_W:0] next_ticks;
		logic [BYTE_W-1:0] slot;
		logic [BYTE_W-1:0] cur;
		logic [PHASE_W-1:0] ph;
		r = '0;
		if (cmd == CMD_PUSH) begin
			if (kb_count >= QUEUE_DEPTH_DEFAULT) begin
				r.dropped = 1'b1;
			end else begin
				slot = kb_head + kb_count[BYTE_W-1:0];
				kb_queue[slot] = pbyte;
				kb_count = kb_count + 1'b1;
			end
		end else if (kb_count != 0) begin
			next_ticks = {1'b0, kb_ticks} + 1'b1;
			if (next_ticks >= {1'b0, kb_half_period}) begin
				cur = kb_queue[kb_head];
				ph = kb_phase;
				if (ph >= FINAL_PHASE) begin
					// Gap is over: the byte leaves the queue.
					kb_head = kb_head + 1'b1;
					kb_count = kb_count - 1'b1;
					kb_phase = '0;
					kb_clk_lvl = 1'b1;
					r.sent = 1'b1;
				end else begin
					kb_clk_lvl = ph[0];
					if (ph <= PH_START_END) begin
						kb_dat_lvl = 1'b0;
					end else if (ph <= PH_DATA_END) begin
						kb_dat_lvl = cur[int'(ph >> 1) - 1];
					end else if (ph <= PH_PARITY_END) begin
						kb_dat_lvl = ~^cur;
					end else if (ph <= PH_STOP_END) begin
						kb_dat_lvl = 1'b1;
					end else begin
						kb_clk_lvl = 1'b1;
						kb_dat_lvl = 1'b1;
					end
					kb_phase = ph + 1'b1;
				end
				kb_ticks = '0;
			end else begin
				kb_ticks = next_ticks[TICK_W-1:0];
			end
		end
		r.clock = kb_clk_lvl;
		r.data = kb_dat_lvl;
		r.count = kb_count;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
		end
	endtask

	// Input driver: offers queued items with a random gap after each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= CMD_TICK;
			send_gap <= 0;
			send_burst <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_items.size() != 0) begin
				next_item = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_item.cmd;
				s_tdata <= next_item.data;
				send_gap <= pick_wait(send_burst);
				if ($urandom_range(0, 31) == 0)
					send_burst <= !send_burst;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor: tracks register writes, predicts each accepted item,
	// checks each accepted result and paces m_tready.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		line_result_t want;
		int recv_wait;
		if (!arst_n) begin
			m_tready <= 1'b1;
			recv_left <= 0;
			recv_burst <= 1'b0;
			kb_head = '0;
			kb_count = '0;
			kb_phase = '0;
			kb_ticks = '0;
			kb_clk_lvl = 1'b1;
			kb_dat_lvl = 1'b1;
			kb_half_period = HALF_PERIOD_RESET;
		end else begin
			if (psel && penable && pwrite && pready && paddr == HALF_PERIOD_ADDR)
				kb_half_period = pwdata[TICK_W-1:0];
			if (s_tvalid && s_tready) begin
				predict_line_levels(s_tuser, s_tdata, want);
				line_expect_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (line_expect_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("result %0d: unexpected item %h", results_seen, m_tdata);
				end else begin
					want = line_expect_q.pop_front();
					check_field("line_clock", want.clock, m_tdata[OUT_CLOCK_BIT]);
					check_field("line_data", want.data, m_tdata[OUT_DATA_BIT]);
					check_field("queue_count", want.count,
						m_tdata[OUT_COUNT_MSB:OUT_COUNT_LSB]);
					check_field("push_dropped", want.dropped, m_tdata[OUT_DROPPED_BIT]);
					check_field("byte_sent", want.sent, m_tdata[OUT_SENT_BIT]);
					check_field("padding", 0, m_tdata[OUT_TDATA_W-1:OUT_SENT_BIT+1]);
				end
				// One long hold-off lets the block back up and stall its input.
				if (results_seen == HOLD_AT_RESULT)
					recv_wait = HOLD_CYCLES;
				else
					recv_wait = pick_wait(recv_burst);
				if ($urandom_range(0, 31) == 0)
					recv_burst <= !recv_burst;
				m_tready <= (recv_wait == 0);
				recv_left <= recv_wait;
			end else if (recv_left != 0) begin
				recv_left <= recv_left - 1;
				m_tready <= (recv_left == 1);
			end
		end
	end

	// Watchdog: ends the run after a long stretch with no handshake.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic apb_access(input logic wr, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Upper bits of the write data carry noise that the register must drop.
	task automatic write_reg(input logic [2:0] addr, input logic [TICK_W-1:0] value);
		logic [31:0] unused;
		apb_access(1'b1, addr, {16'($urandom_range(0, 65535)), value}, unused);
	endtask

	task automatic check_half_period();
		logic [31:0] rd;
		apb_access(1'b0, HALF_PERIOD_ADDR, '0, rd);
		check_field("half_period readback", {16'h0, kb_half_period}, rd);
	endtask

	task automatic queue_item(input logic cmd, input logic [BYTE_W-1:0] data);
		key_item_t it;
		it.cmd = cmd;
		it.data = data;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic queue_random_items(input int n, input int push_pct);
		for (int i = 0; i < n; i++)
			queue_item(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_TICK,
				$urandom_range(0, 255));
	endtask

	task automatic wait_all_results();
		while (results_seen != items_queued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_setting(input logic [TICK_W-1:0] hp, input int n, input int push_pct);
		write_reg(HALF_PERIOD_ADDR, hp);
		@(negedge clk);
		queue_random_items(n, push_pct);
		wait_all_results();
	endtask

	initial begin
		int fill;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset value, empty-queue tick, extreme bytes, counting at 2000.
		check_half_period();
		@(negedge clk);
		queue_item(CMD_TICK, 8'hFF);
		queue_item(CMD_PUSH, 8'h00);
		queue_item(CMD_PUSH, 8'hFF);
		for (int i = 0; i < 3; i++)
			queue_item(CMD_TICK, 8'h00);
		wait_all_results();

		// Lowering the period mid-count fires on the next tick; the unused slot is ignored.
		write_reg(HALF_PERIOD_ADDR, 16'd1);
		write_reg(UNUSED_ADDR, 16'd9);
		check_half_period();
		@(negedge clk);
		for (int i = 0; i < 18; i++)
			queue_item(CMD_TICK, 8'($urandom_range(0, 255)));
		wait_all_results();

		// Random traffic over several periods.
		run_setting(16'd1, 150, 5);
		run_setting(16'd2, 120, 3);

		// Longest period: count part way, then lower it below the count.
		write_reg(HALF_PERIOD_ADDR, 16'hFFFF);
		check_half_period();
		@(negedge clk);
		queue_item(CMD_PUSH, 8'($urandom_range(0, 255)));
		for (int i = 0; i < 100; i++)
			queue_item(CMD_TICK, 8'($urandom_range(0, 255)));
		wait_all_results();
		run_setting(16'd3, 120, 8);
		run_setting(16'($urandom_range(1, 4)), 150, 4);

		// Fill the queue to the top, push into it while full, then send a few bytes.
		write_reg(HALF_PERIOD_ADDR, 16'd1);
		@(negedge clk);
		fill = QUEUE_DEPTH_DEFAULT - int'(kb_count) + 6;
		for (int i = 0; i < fill; i++)
			queue_item(CMD_PUSH, 8'($urandom_range(0, 255)));
		for (int i = 0; i < TICKS_PER_BYTE * DRAIN_BYTES + 30; i++)
			queue_item((i % 40 == 39) ? CMD_PUSH : CMD_TICK, 8'($urandom_range(0, 255)));
		wait_all_results();

		repeat (8) @(posedge clk);
		fail_count += line_expect_q.size();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
design/ps2kbs_pkg.sv
design/ps2kbs_ram.sv
design/ps2_keyboard_byte_sender_core.sv
design/ps2kbs_checker.sv
tb/testbench.sv
